// File: design/pssp_pkg.sv
// ----------------------------------------------------------------------------
// pssp_pkg
// Shared types and constants for the pot-speed step pulse generator.
// ----------------------------------------------------------------------------
package pssp_pkg;

    // Item codes
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SPEED = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    // Configuration register indexes
    localparam logic [2:0] CFG_ADC_ZERO  = 3'd0;
    localparam logic [2:0] CFG_ADC_MAX   = 3'd1;
    localparam logic [2:0] CFG_RPM_MIN   = 3'd2;
    localparam logic [2:0] CFG_RPM_MAX   = 3'd3;
    localparam logic [2:0] CFG_TICK_RATE = 3'd4;
    localparam logic [2:0] CFG_STEPS_0   = 3'd5;
    localparam logic [2:0] CFG_STEPS_1   = 3'd6;
    localparam logic [2:0] CFG_STEPS_2   = 3'd7;

    localparam int CFG_DW = 24;

    // Divider widths
    localparam int DIV_NW = 28;   // dividend / quotient
    localparam int DIV_DW = 24;   // divisor / remainder
    localparam int DIV_CW = 5;    // step counter

    localparam logic [9:0]        ADC_FULL    = 10'd1023;
    localparam logic [DIV_DW-1:0] SEC_PER_MIN = DIV_DW'(60);
    localparam logic [15:0]       IV_SAT      = 16'hFFFF;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RPM,
        S_RPM_WAIT,
        S_FREQ,
        S_FREQ_WAIT,
        S_IV,
        S_IV_WAIT,
        S_WRITE
    } t_state;

    // Channel bank control
    typedef struct packed {
        logic        tick;
        logic        stop;
        logic        wr;
        logic [1:0]  idx;
        logic [15:0] iv;
    } t_chan_ctl;

endpackage

// File: design/pot_speed_step_pulse_generator.sv
// Tick, stop and unused items reach the output register in the cycle after the
// transaction; a speed item goes through S_RPM to S_WRITE outside the window and
// otherwise through up to three passes of one shared 28-step divider (rpm scaling,
// steps per second, tick interval), each with a wait state. Throughput: tick, stop
// and unused items one per cycle unless the output stalls; none during a speed item.
// Reset (synchronous, active low): registers to defaults, all motors stopped.
// ----------------------------------------------------------------------------
// pot_speed_step_pulse_generator
// Maps potentiometer samples to stepper step intervals and emits step pulses.
// ----------------------------------------------------------------------------
module pot_speed_step_pulse_generator
    import pssp_pkg::*;
#(
    parameter int MOTORS = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_mode,
    input  logic [1:0]        i_motor_index,
    input  logic [9:0]        i_adc_value,
    // output channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_step_mask,
    output logic [15:0]       o_new_interval
);

    // configuration registers
    logic [9:0]  r_adc_zero;
    logic [10:0] r_adc_max;
    logic [11:0] r_rpm_min;
    logic [11:0] r_rpm_max;
    logic [23:0] r_tick_rate;
    logic [15:0] r_steps0;
    logic [15:0] r_steps1;
    logic [15:0] r_steps2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_zero  <= 10'd0;
            r_adc_max   <= 11'd1024;
            r_rpm_min   <= 12'd0;
            r_rpm_max   <= 12'd100;
            r_tick_rate <= 24'd20000;
            r_steps0    <= 16'd4000;
            r_steps1    <= 16'd4000;
            r_steps2    <= 16'd400;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ADC_ZERO:  r_adc_zero  <= i_cfg_data[9:0];
                CFG_ADC_MAX:   r_adc_max   <= i_cfg_data[10:0];
                CFG_RPM_MIN:   r_rpm_min   <= i_cfg_data[11:0];
                CFG_RPM_MAX:   r_rpm_max   <= i_cfg_data[11:0];
                CFG_TICK_RATE: r_tick_rate <= i_cfg_data[23:0];
                CFG_STEPS_0:   r_steps0    <= i_cfg_data[15:0];
                CFG_STEPS_1:   r_steps1    <= i_cfg_data[15:0];
                CFG_STEPS_2:   r_steps2    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    t_state r_state, n_state;

    logic [1:0]  r_motor, n_motor;
    logic [9:0]  r_adc, n_adc;
    logic [11:0] r_rpm, n_rpm;
    logic [22:0] r_freq, n_freq;
    logic [15:0] r_iv, n_iv;

    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_step_mask, n_step_mask;
    logic [15:0] r_new_iv, n_new_iv;

    logic              w_accept;
    logic              w_idle_ok;
    logic              w_div_start;
    logic [DIV_NW-1:0] w_div_num;
    logic [DIV_DW-1:0] w_div_den;
    logic              w_div_done;
    logic [DIV_NW-1:0] w_div_q;

    t_chan_ctl         w_ctl;
    logic [MOTORS-1:0] w_mask;
    logic [7:0]        w_mask8;

    // speed datapath
    logic        w_in_win;
    logic [11:0] w_hi;
    logic [9:0]  w_span;
    logic [9:0]  w_diff;
    logic [11:0] w_rng;
    logic [21:0] w_prod_rpm;
    logic [15:0] w_steps;
    logic [27:0] w_prod_freq;
    logic [24:0] w_num_iv;

    assign w_in_win    = (r_adc >= r_adc_zero) && ({1'b0, r_adc} < r_adc_max);
    assign w_hi        = (r_rpm_max < r_rpm_min) ? r_rpm_min : r_rpm_max;
    assign w_span      = ADC_FULL - r_adc_zero;
    assign w_diff      = r_adc - r_adc_zero;
    assign w_rng       = w_hi - r_rpm_min;
    assign w_prod_rpm  = {12'd0, w_diff} * {10'd0, w_rng};
    assign w_steps     = (r_motor == 2'd0) ? r_steps0 :
                         (r_motor == 2'd1) ? r_steps1 : r_steps2;
    assign w_prod_freq = {16'd0, r_rpm} * {12'd0, w_steps};
    assign w_num_iv    = {1'b0, r_tick_rate} + {3'd0, r_freq[22:1]};

    // output register must be free after this edge before a transaction
    assign w_idle_ok = (r_state == S_IDLE) && (!r_out_valid || !i_stall);
    assign o_stall   = !w_idle_ok;
    assign w_accept  = i_valid && w_idle_ok;

    assign w_mask8 = 8'(w_mask);

    always_comb begin
        n_state     = r_state;
        n_motor     = r_motor;
        n_adc       = r_adc;
        n_rpm       = r_rpm;
        n_freq      = r_freq;
        n_iv        = r_iv;
        n_out_valid = r_out_valid && i_stall;
        n_step_mask = r_step_mask;
        n_new_iv    = r_new_iv;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        w_ctl       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_motor = i_motor_index;
                    n_adc   = i_adc_value;
                    if (t_mode'(i_mode) == MODE_SPEED && 32'(i_motor_index) < MOTORS) begin
                        n_state = S_RPM;
                    end else begin
                        w_ctl.tick  = (t_mode'(i_mode) == MODE_TICK);
                        w_ctl.stop  = (t_mode'(i_mode) == MODE_STOP);
                        n_out_valid = 1'b1;
                        n_step_mask = (t_mode'(i_mode) == MODE_TICK) ? w_mask8[2:0] : 3'd0;
                        n_new_iv    = 16'd0;
                    end
                end
            end
            S_RPM: begin
                if (!w_in_win) begin
                    n_iv    = 16'd0;
                    n_state = S_WRITE;
                end else if (w_span == 10'd0) begin
                    n_rpm   = r_rpm_min;
                    n_state = S_FREQ;
                end else begin
                    w_div_start = 1'b1;
                    w_div_num   = DIV_NW'(w_prod_rpm);
                    w_div_den   = DIV_DW'(w_span);
                    n_state     = S_RPM_WAIT;
                end
            end
            S_RPM_WAIT: begin
                if (w_div_done) begin
                    // quotient never exceeds the rpm range
                    n_rpm   = r_rpm_min + w_div_q[11:0];
                    n_state = S_FREQ;
                end
            end
            S_FREQ: begin
                w_div_start = 1'b1;
                w_div_num   = w_prod_freq;
                w_div_den   = SEC_PER_MIN;
                n_state     = S_FREQ_WAIT;
            end
            S_FREQ_WAIT: begin
                if (w_div_done) begin
                    n_freq  = w_div_q[22:0];
                    n_state = S_IV;
                end
            end
            S_IV: begin
                if (r_freq == 23'd0) begin
                    n_iv    = 16'd0;
                    n_state = S_WRITE;
                end else begin
                    w_div_start = 1'b1;
                    w_div_num   = DIV_NW'(w_num_iv);
                    w_div_den   = DIV_DW'(r_freq);
                    n_state     = S_IV_WAIT;
                end
            end
            S_IV_WAIT: begin
                if (w_div_done) begin
                    n_iv    = (w_div_q[DIV_NW-1:16] != '0) ? IV_SAT : w_div_q[15:0];
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                w_ctl.wr    = 1'b1;
                w_ctl.idx   = r_motor;
                w_ctl.iv    = r_iv;
                n_out_valid = 1'b1;
                n_step_mask = 3'd0;
                n_new_iv    = r_iv;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_motor     <= n_motor;
        r_adc       <= n_adc;
        r_rpm       <= n_rpm;
        r_freq      <= n_freq;
        r_iv        <= n_iv;
        r_step_mask <= n_step_mask;
        r_new_iv    <= n_new_iv;
    end

    pssp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    pssp_chan #(
        .MOTORS (MOTORS)
    ) u_chan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_mask  (w_mask)
    );

    assign o_valid        = r_out_valid;
    assign o_step_mask    = r_step_mask;
    assign o_new_interval = r_new_iv;

endmodule

// File: design/pssp_div.sv
// ----------------------------------------------------------------------------
// pssp_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pssp_div
    import pssp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_div;
    logic [DIV_DW-1:0] r_rem;

    logic [DIV_DW:0]   w_trial;
    logic              w_ge;
    logic [DIV_DW:0]   w_diff;

    // remainder stays below the divisor, so the shifted trial fits DIV_DW+1 bits
    assign w_trial = {r_rem, r_num[DIV_NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_trial[DIV_DW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;

endmodule

// File: design/pssp_chan.sv
// ----------------------------------------------------------------------------
// pssp_chan
// Per-motor interval store and tick counters; builds the step mask.
// ----------------------------------------------------------------------------
module pssp_chan
    import pssp_pkg::*;
#(
    parameter int MOTORS = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_chan_ctl         i_ctl,
    output logic [MOTORS-1:0] o_mask
);

    logic [15:0] r_iv  [MOTORS];
    logic [15:0] r_cnt [MOTORS];
    logic [15:0] n_iv  [MOTORS];
    logic [15:0] n_cnt [MOTORS];
    logic [15:0] w_inc [MOTORS];

    always_comb begin
        for (int m = 0; m < MOTORS; m++) begin
            w_inc[m]  = r_cnt[m] + 16'd1;
            n_iv[m]   = r_iv[m];
            n_cnt[m]  = r_cnt[m];
            o_mask[m] = 1'b0;
            // stopped motor keeps its count and never steps
            if (i_ctl.tick && r_iv[m] != 16'd0) begin
                if (w_inc[m] >= r_iv[m]) begin
                    n_cnt[m]  = 16'd0;
                    o_mask[m] = 1'b1;
                end else begin
                    n_cnt[m] = w_inc[m];
                end
            end
            if (i_ctl.stop) begin
                n_iv[m] = 16'd0;
            end
            if (i_ctl.wr && 32'(i_ctl.idx) == 32'(m)) begin
                n_iv[m] = i_ctl.iv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MOTORS; m++) begin
                r_iv[m]  <= 16'd0;
                r_cnt[m] <= 16'd0;
            end
        end else begin
            for (int m = 0; m < MOTORS; m++) begin
                r_iv[m]  <= n_iv[m];
                r_cnt[m] <= n_cnt[m];
            end
        end
    end

endmodule

// File: tb/pssp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pssp_checker
// Watches both channels and the register port of the step pulse generator,
// predicts each result from its own copy of the channel state and compares
// every delivered transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module pssp_checker
    import pssp_pkg::*;
#(
    parameter int MOTORS = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_mode,
    input  logic [1:0]        i_motor_index,
    input  logic [9:0]        i_adc_value,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [2:0]        i_step_mask,
    input  logic [15:0]       i_new_interval,
    output int                o_fail_count,
    output int                o_pending
);

    localparam logic [10:0] DEF_ADC_MAX   = 11'd1024;
    localparam logic [11:0] DEF_RPM_MAX   = 12'd100;
    localparam logic [23:0] DEF_TICK_RATE = 24'd20000;
    localparam logic [15:0] DEF_STEPS     = 16'd4000;
    localparam logic [15:0] DEF_STEPS_2   = 16'd400;

    typedef struct packed {
        logic [2:0]  step_mask;
        logic [15:0] new_interval;
    } t_step_result;

    logic [9:0]   zero_thr;
    logic [10:0]  max_thr;
    logic [11:0]  rpm_lo;
    logic [11:0]  rpm_hi;
    logic [23:0]  tick_hz;
    logic [15:0]  motor_steps [3];
    logic [15:0]  interval_q [MOTORS];
    logic [15:0]  count_q [MOTORS];
    t_step_result result_q [$];
    int           fail_count = 0;

    // Sample -> rpm -> steps per second -> rounded tick interval
    function automatic logic [15:0] speed_interval(int unsigned motor, logic [9:0] adc);
        logic [31:0] top_rpm;
        logic [31:0] span;
        logic [31:0] rpm;
        logic [31:0] steps;
        logic [31:0] freq;
        logic [31:0] iv;
        if (adc < zero_thr || 11'(adc) >= max_thr)
            return 16'd0;
        top_rpm = (rpm_hi < rpm_lo) ? 32'(rpm_lo) : 32'(rpm_hi);
        span    = 32'(ADC_FULL) - 32'(zero_thr);
        rpm     = 32'(rpm_lo);
        if (span != 0)
            rpm = rpm + ((32'(adc) - 32'(zero_thr)) * (top_rpm - 32'(rpm_lo))) / span;
        steps = 32'(motor_steps[(motor < 3) ? motor : 2]);
        freq  = (rpm * steps) / 32'(SEC_PER_MIN);
        if (freq == 0)
            return 16'd0;
        iv = (32'(tick_hz) + freq / 2) / freq;
        if (iv > 32'(IV_SAT))
            iv = 32'(IV_SAT);
        return iv[15:0];
    endfunction

    always @(posedge i_clk) begin : monitor
        t_step_result exp_r;
        t_step_result got_r;
        logic [15:0]  cnt;
        if (!i_rst_n) begin
            zero_thr = '0;
            max_thr  = DEF_ADC_MAX;
            rpm_lo   = '0;
            rpm_hi   = DEF_RPM_MAX;
            tick_hz  = DEF_TICK_RATE;
            motor_steps[0] = DEF_STEPS;
            motor_steps[1] = DEF_STEPS;
            motor_steps[2] = DEF_STEPS_2;
            for (int i = 0; i < MOTORS; i++) begin
                interval_q[i] = '0;
                count_q[i]    = '0;
            end
            result_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ADC_ZERO:  zero_thr = i_cfg_data[9:0];
                    CFG_ADC_MAX:   max_thr  = i_cfg_data[10:0];
                    CFG_RPM_MIN:   rpm_lo   = i_cfg_data[11:0];
                    CFG_RPM_MAX:   rpm_hi   = i_cfg_data[11:0];
                    CFG_TICK_RATE: tick_hz  = i_cfg_data[23:0];
                    CFG_STEPS_0:   motor_steps[0] = i_cfg_data[15:0];
                    CFG_STEPS_1:   motor_steps[1] = i_cfg_data[15:0];
                    CFG_STEPS_2:   motor_steps[2] = i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // the result is registered, so the output always belongs to an
            // older transaction than one accepted at the same edge
            if (i_out_valid && !i_out_stall) begin
                got_r = '{i_step_mask, i_new_interval};
                if (result_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none, actual mask %h interval %h",
                             $time, got_r.step_mask, got_r.new_interval);
                end else begin
                    exp_r = result_q.pop_front();
                    if (got_r.step_mask !== exp_r.step_mask) begin
                        fail_count++;
                        $display("%0t: step_mask mismatch: expected %h actual %h",
                                 $time, exp_r.step_mask, got_r.step_mask);
                    end
                    if (got_r.new_interval !== exp_r.new_interval) begin
                        fail_count++;
                        $display("%0t: new_interval mismatch: expected %h actual %h",
                                 $time, exp_r.new_interval, got_r.new_interval);
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                exp_r = '0;
                case (i_mode)
                    MODE_TICK: begin
                        for (int i = 0; i < MOTORS; i++) begin
                            if (interval_q[i] != 0) begin
                                cnt = count_q[i] + 16'd1;
                                if (cnt >= interval_q[i]) begin
                                    cnt = '0;
                                    exp_r.step_mask[i] = 1'b1;
                                end
                                count_q[i] = cnt;
                            end
                        end
                    end
                    MODE_SPEED: begin
                        // out-of-range motor: nothing changes
                        if (i_motor_index < MOTORS) begin
                            interval_q[i_motor_index] =
                                speed_interval(i_motor_index, i_adc_value);
                            exp_r.new_interval = interval_q[i_motor_index];
                        end
                    end
                    MODE_STOP: begin
                        // counters are kept
                        for (int i = 0; i < MOTORS; i++)
                            interval_q[i] = '0;
                    end
                    default: ;
                endcase
                result_q.push_back(exp_r);
            end
        end
        o_pending    = result_q.size();
        o_fail_count = fail_count;
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the step pulse generator: directed edge cases, then random
// speed/tick/stop traffic under several register settings with random gaps
// and output stalls, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import pssp_pkg::*;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [2:0]        i_cfg_idx     = '0;
    logic [CFG_DW-1:0] i_cfg_data    = '0;
    logic              i_valid       = 1'b0;
    logic              o_stall;
    logic [1:0]        i_mode        = '0;
    logic [1:0]        i_motor_index = '0;
    logic [9:0]        i_adc_value   = '0;
    logic              o_valid;
    logic              i_stall       = 1'b0;
    logic [2:0]        o_step_mask;
    logic [15:0]       o_new_interval;

    int fail_count;
    int pending;
    bit long_hold_req = 1'b0;
    bit burst         = 1'b0;
    int n_items       = 0;
    int n_ticks       = 0;
    int n_speed       = 0;
    int n_settings    = 0;

    pot_speed_step_pulse_generator #(
        .MOTORS(3)
    ) u_dut (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data,
        .i_valid,
        .o_stall,
        .i_mode,
        .i_motor_index,
        .i_adc_value,
        .o_valid,
        .i_stall,
        .o_step_mask,
        .o_new_interval
    );

    pssp_checker #(
        .MOTORS(3)
    ) u_checker (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data,
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_mode,
        .i_motor_index,
        .i_adc_value,
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_step_mask    (o_step_mask),
        .i_new_interval (o_new_interval),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: random stall before each transaction, one long hold on request
    initial begin : result_sink
        int hold;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = 200;
            end else begin
                hold = burst ? 0 : $urandom_range(0, 3);
            end
            repeat (hold) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_item(t_mode mode, logic [1:0] motor, logic [9:0] adc);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_motor_index <= motor;
        i_adc_value   <= adc;
        do @(posedge i_clk); while (o_stall);
        n_items++;
        if (mode == MODE_TICK)
            n_ticks++;
        if (mode == MODE_SPEED)
            n_speed++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DW'(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic apply_settings(int unsigned zero, int unsigned maxt, int unsigned rmin,
                                  int unsigned rmax, int unsigned rate, int unsigned s0,
                                  int unsigned s1, int unsigned s2);
        wait_idle();
        write_reg(CFG_ADC_ZERO, zero);
        write_reg(CFG_ADC_MAX, maxt);
        write_reg(CFG_RPM_MIN, rmin);
        write_reg(CFG_RPM_MAX, rmax);
        write_reg(CFG_TICK_RATE, rate);
        write_reg(CFG_STEPS_0, s0);
        write_reg(CFG_STEPS_1, s1);
        write_reg(CFG_STEPS_2, s2);
        n_settings++;
    endtask

    task automatic random_traffic(int count);
        int    pick;
        t_mode mode;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                mode = MODE_TICK;
            else if (pick < 88)
                mode = MODE_SPEED;
            else if (pick < 94)
                mode = MODE_STOP;
            else
                mode = MODE_NONE;
            send_item(mode,
                      ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                      10'($urandom_range(0, 1023)));
        end
    endtask

    task automatic random_settings();
        int unsigned zero;
        zero = $urandom_range(0, 1022);
        if ($urandom_range(0, 1))
            zero = $urandom_range(0, 200);
        apply_settings(zero, $urandom_range(zero + 1, 1024), $urandom_range(0, 4095),
                       $urandom_range(0, 4095),
                       $urandom_range(0, 1) ? $urandom_range(1, 50000)
                                            : $urandom_range(1, 16777215),
                       $urandom_range(1, 65535), $urandom_range(1, 65535),
                       $urandom_range(1, 65535));
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: idle tick, both sample extremes, out-of-range motor,
        // unused mode, interval lowered under a running counter, stop
        send_item(MODE_TICK, 2'd0, 10'd0);
        send_item(MODE_SPEED, 2'd0, 10'd0);
        send_item(MODE_SPEED, 2'd0, 10'd1023);
        send_item(MODE_SPEED, 2'd1, 10'd512);
        send_item(MODE_SPEED, 2'd2, 10'd1023);
        send_item(MODE_SPEED, 2'd3, 10'd1023);
        send_item(MODE_NONE, 2'd3, 10'h3FF);
        repeat (4) send_item(MODE_TICK, 2'd0, 10'd0);
        send_item(MODE_SPEED, 2'd0, 10'd50);
        repeat (5) send_item(MODE_TICK, 2'd0, 10'd0);
        send_item(MODE_SPEED, 2'd0, 10'd1023);
        send_item(MODE_TICK, 2'd0, 10'd0);
        send_item(MODE_STOP, 2'd0, 10'd0);
        repeat (2) send_item(MODE_TICK, 2'd0, 10'd0);
        random_traffic(80);

        // Lowest register values
        apply_settings(0, 1, 0, 0, 1, 1, 1, 1);
        send_item(MODE_SPEED, 2'd0, 10'd0);
        send_item(MODE_SPEED, 2'd1, 10'd1);
        random_traffic(40);

        // Highest register values
        apply_settings(1022, 1024, 4095, 4095, 16777215, 65535, 65535, 65535);
        send_item(MODE_SPEED, 2'd0, 10'd1021);
        send_item(MODE_SPEED, 2'd1, 10'd1022);
        send_item(MODE_SPEED, 2'd2, 10'd1023);
        random_traffic(60);

        // One step per second at the top tick rate: interval saturates
        apply_settings(0, 1024, 1, 1, 16777215, 60, 60, 61);
        send_item(MODE_SPEED, 2'd0, 10'd700);
        send_item(MODE_SPEED, 2'd2, 10'd0);
        random_traffic(30);

        // Zero threshold at full scale: no span, rpm stays at its minimum
        apply_settings(1023, 1024, 200, 4000, 20000, 200, 300, 400);
        send_item(MODE_SPEED, 2'd0, 10'd1023);
        send_item(MODE_SPEED, 2'd1, 10'd1022);
        random_traffic(40);

        // Full-scale rpm below the minimum
        apply_settings(100, 900, 3000, 100, 1000000, 1000, 2000, 400);
        send_item(MODE_SPEED, 2'd0, 10'd100);
        send_item(MODE_SPEED, 2'd1, 10'd899);
        send_item(MODE_SPEED, 2'd2, 10'd900);
        random_traffic(60);

        // Short intervals; hold the output off so the block backs up
        apply_settings(0, 1024, 600, 4095, 4000, 60, 120, 400);
        send_item(MODE_SPEED, 2'd0, 10'd512);
        send_item(MODE_SPEED, 2'd1, 10'd1023);
        send_item(MODE_SPEED, 2'd2, 10'd300);
        long_hold_req = 1'b1;
        repeat (40) send_item(MODE_TICK, 2'd0, 10'd0);
        burst = 1'b1;
        random_traffic(80);
        burst = 1'b0;

        repeat (3) begin
            random_settings();
            random_traffic(70);
        end

        wait_idle();
        repeat (100) @(negedge i_clk);

        $display("summary: %0d transactions (%0d ticks, %0d speed) over %0d register settings",
                 n_items, n_ticks, n_speed, n_settings);
        $display("summary: window edges, saturation, empty span, inverted rpm, long output hold");
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
design/pssp_pkg.sv
design/pssp_div.sv
design/pssp_chan.sv
design/pot_speed_step_pulse_generator.sv
tb/pssp_checker.sv
tb/tb_top.sv
